// ===== design/acm_pkg.sv =====
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types and constants for the AT command line matcher.
// ----------------------------------------------------------------------------
package acm_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int LINE_CHARS_DEF    = 64;
    localparam int TABLE_ENTRIES_DEF = 6;
    localparam int NAME_CHARS_DEF    = 8;

    // Fixed field widths
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 3;
    localparam int NAME_W      = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CNT_REG_W   = 3;

    // Longest argument run delivered for one line
    localparam int RESULT_LIMIT = 63;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_0        = 3'd1;

    // Characters of interest
    localparam logic [CHAR_W-1:0] CH_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_T   = 8'h54;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_EQ  = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

    typedef enum logic [2:0] {
        ST_WAIT_A,
        ST_WAIT_T,
        ST_COLLECT,
        ST_END,
        ST_CMP,
        ST_SEL,
        ST_EMIT
    } t_state;

endpackage

// ===== design/at_command_line_matcher_top.sv =====
// ----------------------------------------------------------------------------
// at_command_line_matcher_top
// Collects an AT command line into a line memory, matches the command part
// against a table of names and streams out the argument characters.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  rx      | in        | i_valid / o_stall    | i_rx_char
//  result  | out       | o_valid / i_stall    | o_command_index, o_arg_char,
//          |           |                      | o_has_arg, o_last
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Flow: one character per cycle while a line is being collected. On the
//  terminating CR/LF the input stalls for a compare sweep (one line-memory
//  read per name position, all names checked in parallel), then a table
//  select state, then one argument beat per cycle while the output is not
//  stalled, as the single registered memory read port streams it out.
//  Reset: synchronous, active low; clears control and configuration state
//  only. The line memory is never cleared: only current-line entries are used.
//  Stalls: the output register and the read data stage form a two-deep
//  pipe; a downstream stall holds both, and input resumes once the last
//  argument read has landed in the output register.
// ----------------------------------------------------------------------------
module at_command_line_matcher_top #(
    parameter int LINE_CHARS    = acm_pkg::LINE_CHARS_DEF,
    parameter int TABLE_ENTRIES = acm_pkg::TABLE_ENTRIES_DEF,
    parameter int NAME_CHARS    = acm_pkg::NAME_CHARS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // character input
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [acm_pkg::CHAR_W-1:0]     i_rx_char,
    // result output
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [acm_pkg::IDX_W-1:0]      o_command_index,
    output logic [acm_pkg::CHAR_W-1:0]     o_arg_char,
    output logic                           o_has_arg,
    output logic                           o_last,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [acm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acm_pkg::NAME_W-1:0]     i_cfg_data
);
    import acm_pkg::*;

    localparam int LEN_W  = $clog2(LINE_CHARS + 1);   // line length 0..LINE_CHARS
    localparam int ADDR_W = $clog2(LINE_CHARS);       // line memory address
    localparam int NL_W   = $clog2(NAME_CHARS + 1);   // name length 0..NAME_CHARS
    localparam int CMP_W  = LEN_W + CNT_W;            // wide enough for the run clamp

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_REG_W-1:0] r_cmd_count;
    logic [NAME_W-1:0]    r_names [TABLE_ENTRIES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_count <= '0;
            for (int e = 0; e < TABLE_ENTRIES; e++) begin
                r_names[e] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_COMMAND_COUNT) begin
                r_cmd_count <= i_cfg_data[CNT_REG_W-1:0];
            end
            for (int e = 0; e < TABLE_ENTRIES; e++) begin
                if (i_cfg_index == CFG_IDX_W'(CFG_NAME_0 + e)) begin
                    r_names[e] <= i_cfg_data;
                end
            end
        end
    end

    // effective table size
    logic [CNT_REG_W-1:0] cnt_eff;
    assign cnt_eff = (r_cmd_count > CNT_REG_W'(TABLE_ENTRIES)) ?
                     CNT_REG_W'(TABLE_ENTRIES) : r_cmd_count;

    // name lengths: position of the first zero byte, capped at NAME_CHARS
    logic [NL_W-1:0] nl [TABLE_ENTRIES];

    always_comb begin
        logic hit_zero;
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            nl[e]    = '0;
            hit_zero = 1'b0;
            for (int k = 0; k < NAME_CHARS; k++) begin
                if (!hit_zero && r_names[e][8*k +: 8] != CH_NUL) begin
                    nl[e] = NL_W'(k + 1);
                end else begin
                    hit_zero = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [LEN_W-1:0]  r_len;       // stored characters
    logic [LEN_W-1:0]  r_t;         // text length (chars before first NUL)
    logic              r_zero_seen;
    logic [LEN_W-1:0]  r_eq_pos;    // first '=' within the text
    logic              r_eq_seen;

    logic [NL_W-1:0]   r_k;         // compare read position
    logic              r_cmp_vld;
    logic [NL_W-1:0]   r_cmp_idx;
    logic [TABLE_ENTRIES-1:0] r_eq; // name still equal so far

    logic [IDX_W-1:0]  r_sel_idx;
    logic [ADDR_W-1:0] r_ptr;
    logic [CNT_W-1:0]  r_rem;
    logic              r_empty;

    logic              r_rd_vld;    // argument read data waiting
    logic              r_rd_last;
    logic [CHAR_W-1:0] r_rd_data;

    logic              r_out_vld;
    logic [IDX_W-1:0]  r_out_idx;
    logic [CHAR_W-1:0] r_out_arg;
    logic              r_out_has;
    logic              r_out_last;

    // line memory
    logic [CHAR_W-1:0] r_line_mem [LINE_CHARS];

    logic acc, is_crlf, is_full;
    logic cmp_issue, emit_issue, load_empty, load_out, adv, rd_free;
    logic rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign acc     = i_valid && !o_stall;
    assign is_crlf = (i_rx_char == CH_CR) || (i_rx_char == CH_LF);
    assign is_full = (r_len >= LEN_W'(LINE_CHARS));

    // output register may load this cycle
    assign adv      = !r_out_vld || !i_stall;
    assign rd_free  = !r_rd_vld || adv;
    assign load_out = adv && r_rd_vld;

    // table select
    logic [LEN_W-1:0]  cmd_len;
    logic              sel_hit;
    logic [IDX_W-1:0]  sel_idx;
    logic [NL_W-1:0]   sel_nl;
    logic [LEN_W-1:0]  sel_start;
    logic [LEN_W-1:0]  sel_span;
    logic [CNT_W-1:0]  sel_count;

    assign cmd_len = r_eq_seen ? r_eq_pos : r_len;

    always_comb begin
        sel_hit = 1'b0;
        sel_idx = '0;
        sel_nl  = '0;
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            if (!sel_hit && (IDX_W'(e) < IDX_W'(cnt_eff)) && r_eq[e] &&
                ((cmd_len <= LEN_W'(nl[e])) || (r_t == LEN_W'(nl[e])))) begin
                sel_hit = 1'b1;
                sel_idx = IDX_W'(e);
                sel_nl  = nl[e];
            end
        end
        sel_start = (LEN_W'(sel_nl) < r_t) ? LEN_W'(sel_nl) : r_t;
        sel_span  = r_t - sel_start;
        sel_count = (CMP_W'(sel_span) > CMP_W'(RESULT_LIMIT)) ?
                    CNT_W'(RESULT_LIMIT) : CNT_W'(sel_span);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_WAIT_A: begin
                if (acc && i_rx_char == CH_A) n_state = ST_WAIT_T;
            end
            ST_WAIT_T: begin
                if (acc) n_state = (i_rx_char == CH_T) ? ST_COLLECT : ST_WAIT_A;
            end
            ST_COLLECT: begin
                if (acc && (is_crlf || is_full)) n_state = ST_END;
            end
            ST_END: begin
                if (acc) n_state = is_crlf ? ST_CMP : ST_WAIT_A;
            end
            ST_CMP: begin
                if (r_k == NL_W'(NAME_CHARS) && !r_cmp_vld) n_state = ST_SEL;
            end
            ST_SEL: begin
                n_state = sel_hit ? ST_EMIT : ST_WAIT_A;
            end
            ST_EMIT: begin
                if (r_empty) begin
                    if (adv) n_state = ST_WAIT_A;
                end else if (r_rem == '0 && !r_rd_vld) begin
                    n_state = ST_WAIT_A;
                end
            end
            default: n_state = ST_WAIT_A;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall    = 1'b1;
        cmp_issue  = 1'b0;
        emit_issue = 1'b0;
        load_empty = 1'b0;
        unique case (r_state)
            ST_WAIT_A, ST_WAIT_T, ST_COLLECT, ST_END: begin
                o_stall = 1'b0;
            end
            ST_CMP: begin
                cmp_issue = (r_k != NL_W'(NAME_CHARS));
            end
            ST_SEL: begin
            end
            ST_EMIT: begin
                load_empty = r_empty && adv;
                emit_issue = !r_empty && (r_rem != '0) && rd_free;
            end
            default: begin
            end
        endcase
    end

    assign rd_en   = cmp_issue || emit_issue;
    assign rd_addr = cmp_issue ? ADDR_W'(r_k) : r_ptr;

    // line memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (acc && r_state == ST_COLLECT && !is_crlf && !is_full) begin
            r_line_mem[r_len[ADDR_W-1:0]] <= i_rx_char;
        end
        if (rd_en) begin
            r_rd_data <= r_line_mem[rd_addr];
        end
    end

    // compare byte: text positions past the NUL read as zero
    logic [CHAR_W-1:0] cmp_byte;
    assign cmp_byte = (LEN_W'(r_cmp_idx) < r_t) ? r_rd_data : CH_NUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT_A;
            r_len       <= '0;
            r_t         <= '0;
            r_zero_seen <= 1'b0;
            r_eq_pos    <= '0;
            r_eq_seen   <= 1'b0;
            r_k         <= '0;
            r_cmp_vld   <= 1'b0;
            r_eq        <= '0;
            r_rem       <= '0;
            r_empty     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;

            // line bookkeeping
            if (acc && r_state == ST_WAIT_T) begin
                r_len       <= '0;
                r_t         <= '0;
                r_zero_seen <= 1'b0;
                r_eq_seen   <= 1'b0;
            end
            if (acc && r_state == ST_COLLECT && !is_crlf && !is_full) begin
                r_len <= r_len + 1'b1;
                if (!r_zero_seen) begin
                    if (i_rx_char == CH_NUL) begin
                        r_zero_seen <= 1'b1;
                    end else begin
                        r_t <= r_len + 1'b1;
                        if (!r_eq_seen && i_rx_char == CH_EQ) begin
                            r_eq_seen <= 1'b1;
                            r_eq_pos  <= r_len;
                        end
                    end
                end
            end

            // compare sweep over the name positions
            if (acc && r_state == ST_END && is_crlf) begin
                r_k  <= '0;
                r_eq <= '1;
            end
            if (cmp_issue) r_k <= r_k + 1'b1;
            r_cmp_vld <= cmp_issue;
            if (r_cmp_vld) begin
                for (int e = 0; e < TABLE_ENTRIES; e++) begin
                    if (r_cmp_idx < nl[e] && r_names[e][r_cmp_idx*8 +: 8] != cmp_byte) begin
                        r_eq[e] <= 1'b0;
                    end
                end
            end

            // run setup
            if (r_state == ST_SEL) begin
                r_rem   <= sel_count;
                r_empty <= (sel_count == '0);
            end
            if (emit_issue) r_rem <= r_rem - 1'b1;

            // read stage and output register
            if (emit_issue) begin
                r_rd_vld <= 1'b1;
            end else if (load_out) begin
                r_rd_vld <= 1'b0;
            end
            if (adv) r_out_vld <= load_out || load_empty;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_k;
        if (r_state == ST_SEL) begin
            r_sel_idx <= sel_idx;
            r_ptr     <= ADDR_W'(sel_start);
        end
        if (emit_issue) begin
            r_ptr     <= r_ptr + 1'b1;
            r_rd_last <= (r_rem == CNT_W'(1));
        end
        if (load_out) begin
            r_out_idx  <= r_sel_idx;
            r_out_arg  <= r_rd_data;
            r_out_has  <= 1'b1;
            r_out_last <= r_rd_last;
        end else if (load_empty) begin
            r_out_idx  <= r_sel_idx;
            r_out_arg  <= CH_NUL;
            r_out_has  <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_command_index = r_out_idx;
    assign o_arg_char      = r_out_arg;
    assign o_has_arg       = r_out_has;
    assign o_last          = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rd_in_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_state == ST_EMIT)
        else $error("argument read pending outside emit");

    a_cmp_in_cmp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> r_state == ST_CMP)
        else $error("compare data outside compare sweep");

    a_text_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t <= r_len && r_len <= LEN_W'(LINE_CHARS))
        else $error("text length beyond stored length");

    a_run_open : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> r_state == ST_EMIT)
        else $error("non-final beat with the run already closed");

    a_empty_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_arg) |-> (o_last && o_arg_char == CH_NUL))
        else $error("empty argument beat must be final and zero");

endmodule
